FILE: rtl/core/svt_pkg.sv
package svt_pkg;

  localparam int unsigned PriceW = 24;
  localparam int unsigned PosW   = 7;
  localparam int unsigned OutCntW = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PriceW-1:0] LowThrRst  = 24'd38400;
  localparam logic [PriceW-1:0] HighThrRst = 24'd396800;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_POS = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_THR  = 1'd0,
    REG_HIGH_THR = 1'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [PriceW-1:0] price;
    logic [PosW-1:0]   position;
  } svt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PriceW-1:0]  read_value;
    logic [OutCntW-1:0] entry_count;
    logic [OutCntW-1:0] count_below;
    logic [OutCntW-1:0] count_above;
  } svt_rsp_t;

endpackage

FILE: rtl/core/svt_ram.sv
module svt_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sorted_value_table_with_threshold_counts.sv
// done_o is registered and rises after the start is taken, once the S_SCAN sweep and S_FINISH are through
// one item at a time: a new start is taken only in S_IDLE; busy_o stays high through S_SCAN and S_FINISH
// each item sweeps the stored entries once through the two-port table ram, one entry a cycle
// a new start is taken in the cycle that done_o is high; the receiver cannot stall results
// reset: table empty, thresholds back to 150.0 and 1550.0, stored entries left as they are
module sorted_value_table_with_threshold_counts #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  svt_pkg::svt_req_t                     req_i,
  output logic                                  done_o,
  output svt_pkg::svt_rsp_t                     rsp_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [svt_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [svt_pkg::PriceW-1:0]            cfg_data_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > svt_pkg::PosW) ? CW : svt_pkg::PosW;
  localparam int unsigned PW = svt_pkg::PriceW;

  svt_pkg::state_e state_q, state_d;

  logic [PW-1:0] low_q, high_q;
  logic [1:0]    op_q, op_d;
  logic [PW-1:0] price_q, price_d;
  logic [svt_pkg::PosW-1:0] pos_q, pos_d;
  logic          ins_ok_q, ins_ok_d;
  logic          del_ok_q, del_ok_d;
  logic          rd_ok_q, rd_ok_d;
  logic          placed_q, placed_d;
  logic [1:0]    status_q, status_d;
  logic [PW-1:0] rdval_q, rdval_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] below_q, below_d;
  logic [CW-1:0] above_q, above_d;
  logic [CW-1:0] iss_cnt_q, iss_cnt_d;
  logic [AW-1:0] iss_addr_q, iss_addr_d;
  logic [AW-1:0] tag_q, tag_d;
  logic          rv_q, rv_d;
  logic          done_q, done_d;
  svt_pkg::svt_rsp_t rsp_q, rsp_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [PW-1:0] wdata;
  logic          re;
  logic [PW-1:0] rdata;
  logic          skip;
  logic [CW-1:0] cnt_fin;

  svt_ram #(
    .Depth(CAPACITY),
    .Width(PW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(iss_addr_q),
    .rdata_o(rdata)
  );

  assign busy_o      = (state_q != svt_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == svt_pkg::S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= svt_pkg::LowThrRst;
      high_q <= svt_pkg::HighThrRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        svt_pkg::REG_LOW_THR:  low_q  <= cfg_data_i;
        svt_pkg::REG_HIGH_THR: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= svt_pkg::S_IDLE;
      op_q       <= '0;
      ins_ok_q   <= 1'b0;
      del_ok_q   <= 1'b0;
      rd_ok_q    <= 1'b0;
      placed_q   <= 1'b0;
      count_q    <= '0;
      iss_cnt_q  <= '0;
      iss_addr_q <= '0;
      tag_q      <= '0;
      rv_q       <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      ins_ok_q   <= ins_ok_d;
      del_ok_q   <= del_ok_d;
      rd_ok_q    <= rd_ok_d;
      placed_q   <= placed_d;
      count_q    <= count_d;
      iss_cnt_q  <= iss_cnt_d;
      iss_addr_q <= iss_addr_d;
      tag_q      <= tag_d;
      rv_q       <= rv_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
    below_q  <= below_d;
    above_q  <= above_d;
    rsp_q    <= rsp_d;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    price_d    = price_q;
    pos_d      = pos_q;
    ins_ok_d   = ins_ok_q;
    del_ok_d   = del_ok_q;
    rd_ok_d    = rd_ok_q;
    placed_d   = placed_q;
    status_d   = status_q;
    rdval_d    = rdval_q;
    count_d    = count_q;
    below_d    = below_q;
    above_d    = above_q;
    iss_cnt_d  = iss_cnt_q;
    iss_addr_d = iss_addr_q;
    tag_d      = tag_q;
    rv_d       = 1'b0;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    skip       = 1'b0;
    cnt_fin    = count_q;

    case (state_q)
      svt_pkg::S_IDLE: begin
        if (start_i) begin
          op_d     = req_i.op;
          price_d  = req_i.price;
          pos_d    = req_i.position;
          ins_ok_d = (req_i.op == svt_pkg::OP_INSERT) && (count_q < CW'(CAPACITY));
          del_ok_d = (req_i.op == svt_pkg::OP_DELETE) &&
                     (XW'(req_i.position) < XW'(count_q));
          rd_ok_d  = (req_i.op == svt_pkg::OP_READ) &&
                     (XW'(req_i.position) < XW'(count_q));
          status_d = svt_pkg::STATUS_OK;
          if ((req_i.op == svt_pkg::OP_INSERT) && !(count_q < CW'(CAPACITY))) begin
            status_d = svt_pkg::STATUS_FULL;
          end else if (((req_i.op == svt_pkg::OP_DELETE) ||
                        (req_i.op == svt_pkg::OP_READ)) &&
                       !(XW'(req_i.position) < XW'(count_q))) begin
            status_d = svt_pkg::STATUS_BAD_POS;
          end
          placed_d  = 1'b0;
          rdval_d   = '0;
          below_d   = '0;
          above_d   = '0;
          iss_cnt_d = count_q;
          if (req_i.op == svt_pkg::OP_INSERT) begin
            iss_addr_d = AW'(count_q - CW'(1));
          end else begin
            iss_addr_d = '0;
          end
          state_d = svt_pkg::S_SCAN;
        end
      end

      svt_pkg::S_SCAN: begin
        if (iss_cnt_q != '0) begin
          re        = 1'b1;
          rv_d      = 1'b1;
          tag_d     = iss_addr_q;
          iss_cnt_d = iss_cnt_q - CW'(1);
          if (op_q == svt_pkg::OP_INSERT) begin
            iss_addr_d = iss_addr_q - AW'(1);
          end else begin
            iss_addr_d = iss_addr_q + AW'(1);
          end
        end else begin
          state_d = svt_pkg::S_FINISH;
        end
        if (rv_q) begin
          // entries sweep upward one slot until the new price finds its place
          if (ins_ok_q && !placed_q) begin
            we    = 1'b1;
            waddr = tag_q + AW'(1);
            if (rdata > price_q) begin
              wdata = rdata;
            end else begin
              wdata    = price_q;
              placed_d = 1'b1;
            end
          end
          if (del_ok_q && (XW'(tag_q) > XW'(pos_q))) begin
            we    = 1'b1;
            waddr = tag_q - AW'(1);
            wdata = rdata;
          end
          if (rd_ok_q && (XW'(tag_q) == XW'(pos_q))) begin
            rdval_d = rdata;
          end
          skip = del_ok_q && (XW'(tag_q) == XW'(pos_q));
          if (!skip) begin
            below_d = below_q + CW'(rdata < low_q);
            above_d = above_q + CW'(rdata > high_q);
          end
        end
      end

      svt_pkg::S_FINISH: begin
        if (ins_ok_q && !placed_q) begin
          we    = 1'b1;
          waddr = '0;
          wdata = price_q;
        end
        if (ins_ok_q) begin
          cnt_fin = count_q + CW'(1);
        end else if (del_ok_q) begin
          cnt_fin = count_q - CW'(1);
        end
        count_d           = cnt_fin;
        rsp_d.status      = status_q;
        rsp_d.read_value  = rdval_q;
        rsp_d.entry_count = svt_pkg::OutCntW'(cnt_fin);
        rsp_d.count_below = svt_pkg::OutCntW'(below_q + CW'(ins_ok_q && (price_q < low_q)));
        rsp_d.count_above = svt_pkg::OutCntW'(above_q + CW'(ins_ok_q && (price_q > high_q)));
        done_d            = 1'b1;
        state_d           = svt_pkg::S_IDLE;
      end

      default: begin
        state_d = svt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
